/* rtl/core/olwd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package olwd_pkg;

    localparam int VALUE_W     = 32;
    localparam int ACTION_W    = 3;
    localparam int STATUS_W    = 2;
    localparam int LEN_W       = 7;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [ACTION_W-1:0] ACT_APPEND    = 3'd0;
    localparam logic [ACTION_W-1:0] ACT_DEL_HEAD  = 3'd1;
    localparam logic [ACTION_W-1:0] ACT_DEL_TAIL  = 3'd2;
    localparam logic [ACTION_W-1:0] ACT_DEL_MATCH = 3'd3;
    localparam logic [ACTION_W-1:0] ACT_DUMP      = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

    typedef enum logic [2:0] {
        OP_APPEND,
        OP_DEL_HEAD,
        OP_DEL_TAIL,
        OP_DEL_MATCH,
        OP_DUMP,
        OP_NONE
    } op_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_MATCH,
        BK_DUMP
    } back_state_t;

    typedef struct packed {
        op_t                       op;
        logic signed [VALUE_W-1:0] value;
    } cmd_t;

    function automatic op_t classify(input logic [ACTION_W-1:0] action);
        op_t op;
        case (action)
            ACT_APPEND:    op = OP_APPEND;
            ACT_DEL_HEAD:  op = OP_DEL_HEAD;
            ACT_DEL_TAIL:  op = OP_DEL_TAIL;
            ACT_DEL_MATCH: op = OP_DEL_MATCH;
            ACT_DUMP:      op = OP_DUMP;
            default:       op = OP_NONE;
        endcase
        return op;
    endfunction

endpackage

`default_nettype wire

/* rtl/core/olwd_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module olwd_front (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [olwd_pkg::ACTION_W-1:0]       s_action,
    input  wire logic signed [olwd_pkg::VALUE_W-1:0] s_value,
    output logic                                     cmd_valid,
    input  wire logic                                cmd_ready,
    output olwd_pkg::cmd_t                           cmd
);

    olwd_pkg::cmd_t q_reg [olwd_pkg::QUEUE_DEPTH];
    olwd_pkg::cmd_t q_next [olwd_pkg::QUEUE_DEPTH];
    logic           wr_ptr_reg, wr_ptr_next;
    logic           rd_ptr_reg, rd_ptr_next;
    logic [1:0]     fill_reg, fill_next;
    logic           push, pop;
    olwd_pkg::cmd_t incoming;

    assign s_ready   = (fill_reg != 2'(olwd_pkg::QUEUE_DEPTH));
    assign cmd_valid = (fill_reg != 2'd0);
    assign cmd       = q_reg[rd_ptr_reg];
    assign push      = s_valid && s_ready;
    assign pop       = cmd_valid && cmd_ready;

    // classify the request on entry
    assign incoming.op    = olwd_pkg::classify(s_action);
    assign incoming.value = s_value;

    always_comb begin
        q_next      = q_reg;
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            q_next[wr_ptr_reg] = incoming;
            wr_ptr_next        = ~wr_ptr_reg;
        end
        if (pop) begin
            rd_ptr_next = ~rd_ptr_reg;
        end
        if (push && !pop) begin
            fill_next = fill_reg + 2'd1;
        end else if (pop && !push) begin
            fill_next = fill_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg <= q_next;
    end

endmodule

`default_nettype wire

/* rtl/core/olwd_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module olwd_back #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cmd_valid,
    output logic                                     cmd_ready,
    input  wire olwd_pkg::cmd_t                      cmd,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [olwd_pkg::VALUE_W-1:0]      m_item_value,
    output logic                                     m_last,
    output logic [olwd_pkg::STATUS_W-1:0]            m_status,
    output logic [olwd_pkg::LEN_W-1:0]               m_length
);

    localparam logic [olwd_pkg::LEN_W-1:0] CAP_COUNT = olwd_pkg::LEN_W'(CAPACITY);

    olwd_pkg::back_state_t state_reg, state_next;

    logic signed [olwd_pkg::VALUE_W-1:0] cell_reg  [CAPACITY];
    logic signed [olwd_pkg::VALUE_W-1:0] cell_next [CAPACITY];
    logic signed [olwd_pkg::VALUE_W-1:0] cell_up   [CAPACITY];
    logic [olwd_pkg::LEN_W-1:0]          count_reg, count_next;
    logic [olwd_pkg::LEN_W-1:0]          idx_reg, idx_next;
    logic [CAPACITY-1:0]                 match_reg, match_next;

    logic                                m_valid_reg, m_valid_next;
    logic signed [olwd_pkg::VALUE_W-1:0] m_item_value_reg, m_item_value_next;
    logic                                m_last_reg, m_last_next;
    logic [olwd_pkg::STATUS_W-1:0]       m_status_reg, m_status_next;
    logic [olwd_pkg::LEN_W-1:0]          m_length_reg, m_length_next;

    logic                                out_free, pop, is_empty, is_full, dump_last;
    logic                                emit, found;
    logic signed [olwd_pkg::VALUE_W-1:0] emit_item;
    logic                                emit_last;
    logic [olwd_pkg::STATUS_W-1:0]       emit_status;
    logic [CAPACITY-1:0]                 below_first, first_bit, shift_mask;

    // each cell sees its upper neighbor; the top cell wraps to the head
    for (genvar g = 0; g < CAPACITY; g++) begin : g_up
        if (g < CAPACITY - 1) begin : g_mid
            assign cell_up[g] = cell_reg[g + 1];
        end else begin : g_top
            assign cell_up[g] = cell_reg[0];
        end
    end

    assign out_free  = !m_valid_reg || m_ready;
    assign cmd_ready = (state_reg == olwd_pkg::BK_IDLE) && out_free;
    assign pop       = cmd_valid && cmd_ready;
    assign is_empty  = (count_reg == '0);
    assign is_full   = (count_reg >= CAP_COUNT);
    assign dump_last = ((idx_reg + 7'd1) == count_reg);

    // first match isolation: bits up to and including the first hit
    assign below_first = match_reg ^ (match_reg - CAPACITY'(1));
    assign first_bit   = match_reg & below_first;
    assign shift_mask  = ~below_first | first_bit;
    assign found       = |match_reg;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            olwd_pkg::BK_IDLE: begin
                if (pop && !is_empty) begin
                    if (cmd.op == olwd_pkg::OP_DEL_MATCH) begin
                        state_next = olwd_pkg::BK_MATCH;
                    end else if (cmd.op == olwd_pkg::OP_DUMP) begin
                        state_next = olwd_pkg::BK_DUMP;
                    end
                end
            end
            olwd_pkg::BK_MATCH: begin
                if (out_free) begin
                    state_next = olwd_pkg::BK_IDLE;
                end
            end
            olwd_pkg::BK_DUMP: begin
                if (out_free && dump_last) begin
                    state_next = olwd_pkg::BK_IDLE;
                end
            end
            default: state_next = olwd_pkg::BK_IDLE;
        endcase
    end

    always_comb begin
        cell_next   = cell_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        match_next  = match_reg;
        emit        = 1'b0;
        emit_item   = '0;
        emit_last   = 1'b1;
        emit_status = olwd_pkg::ST_OK;
        case (state_reg)
            olwd_pkg::BK_IDLE: begin
                if (pop) begin
                    case (cmd.op)
                        olwd_pkg::OP_APPEND: begin
                            emit = 1'b1;
                            if (is_full) begin
                                emit_status = olwd_pkg::ST_FULL;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    if (count_reg == 7'(i)) begin
                                        cell_next[i] = cmd.value;
                                    end
                                end
                                count_next = count_reg + 7'd1;
                            end
                        end
                        olwd_pkg::OP_DEL_HEAD: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                emit_status = olwd_pkg::ST_EMPTY;
                            end else begin
                                cell_next  = cell_up;
                                count_next = count_reg - 7'd1;
                            end
                        end
                        olwd_pkg::OP_DEL_TAIL: begin
                            emit = 1'b1;
                            if (is_empty) begin
                                emit_status = olwd_pkg::ST_EMPTY;
                            end else begin
                                count_next = count_reg - 7'd1;
                            end
                        end
                        olwd_pkg::OP_DEL_MATCH: begin
                            if (is_empty) begin
                                emit        = 1'b1;
                                emit_status = olwd_pkg::ST_EMPTY;
                            end else begin
                                for (int i = 0; i < CAPACITY; i++) begin
                                    match_next[i] = (cell_reg[i] == cmd.value) &&
                                                    (7'(i) < count_reg);
                                end
                            end
                        end
                        olwd_pkg::OP_DUMP: begin
                            if (is_empty) begin
                                emit        = 1'b1;
                                emit_status = olwd_pkg::ST_EMPTY;
                            end else begin
                                idx_next = '0;
                            end
                        end
                        default: begin
                            emit = 1'b1;
                        end
                    endcase
                end
            end
            olwd_pkg::BK_MATCH: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (found) begin
                        for (int i = 0; i < CAPACITY; i++) begin
                            if (shift_mask[i]) begin
                                cell_next[i] = cell_up[i];
                            end
                        end
                        count_next = count_reg - 7'd1;
                    end else begin
                        emit_status = olwd_pkg::ST_NOTFOUND;
                    end
                end
            end
            olwd_pkg::BK_DUMP: begin
                if (out_free) begin
                    emit      = 1'b1;
                    emit_item = cell_reg[0];
                    emit_last = dump_last;
                    idx_next  = idx_reg + 7'd1;
                    // rotate so the head returns to cell zero after a full pass
                    for (int i = 0; i < CAPACITY; i++) begin
                        if ((count_reg - 7'd1) == 7'(i)) begin
                            cell_next[i] = cell_reg[0];
                        end else begin
                            cell_next[i] = cell_up[i];
                        end
                    end
                end
            end
            default: begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb begin
        m_valid_next      = m_valid_reg;
        m_item_value_next = m_item_value_reg;
        m_last_next       = m_last_reg;
        m_status_next     = m_status_reg;
        m_length_next     = m_length_reg;
        if (emit) begin
            m_valid_next      = 1'b1;
            m_item_value_next = emit_item;
            m_last_next       = emit_last;
            m_status_next     = emit_status;
            m_length_next     = count_next;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= olwd_pkg::BK_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cell_reg         <= cell_next;
        idx_reg          <= idx_next;
        match_reg        <= match_next;
        m_item_value_reg <= m_item_value_next;
        m_last_reg       <= m_last_next;
        m_status_reg     <= m_status_next;
        m_length_reg     <= m_length_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_item_value = m_item_value_reg;
    assign m_last       = m_last_reg;
    assign m_status     = m_status_reg;
    assign m_length     = m_length_reg;

endmodule

`default_nettype wire

/* rtl/core/ordered_list_with_deletions.sv */
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel (s_valid/s_ready, s_action, s_value): one request per item:
// append, delete head, delete tail, delete first match, or dump.
// Result channel (m_valid/m_ready): each edit answers with one status result;
// a dump streams every entry from head to tail with m_last on the final one,
// or a single empty result. m_length is the entry count after the request.
// Requests enter a two-deep queue; the back end pops one when it is idle and
// its output register is free. Append, delete head, delete tail and unused
// codes show their result in the cycle after they are taken from the queue;
// delete by value first registers a compare across all cells, then does the
// shift; a dump first starts, then rotates the cell row once per entry.
// A stalled receiver holds the result register; the back end waits and the
// queue keeps taking requests until it is full.
// Reset (aresetn low, synchronous) empties the list and the queue and drops
// any pending result. Cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module ordered_list_with_deletions #(
    parameter int CAPACITY = 64
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [olwd_pkg::ACTION_W-1:0]       s_action,
    input  wire logic signed [olwd_pkg::VALUE_W-1:0] s_value,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic signed [olwd_pkg::VALUE_W-1:0]      m_item_value,
    output logic                                     m_last,
    output logic [olwd_pkg::STATUS_W-1:0]            m_status,
    output logic [olwd_pkg::LEN_W-1:0]               m_length
);

    logic           cmd_valid;
    logic           cmd_ready;
    olwd_pkg::cmd_t cmd;

    olwd_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_action  (s_action),
        .s_value   (s_value),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    olwd_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd_valid    (cmd_valid),
        .cmd_ready    (cmd_ready),
        .cmd          (cmd),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_item_value (m_item_value),
        .m_last       (m_last),
        .m_status     (m_status),
        .m_length     (m_length)
    );

    a_status_single : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status != olwd_pkg::ST_OK)) |-> (m_last && (m_item_value == '0)))
        else $error("status result not single or carries a value");

    a_length_bound : assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_length <= olwd_pkg::LEN_W'(CAPACITY)))
        else $error("length beyond capacity");

    a_full_length : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == olwd_pkg::ST_FULL)) |-> (m_length == olwd_pkg::LEN_W'(CAPACITY)))
        else $error("full status with list not full");

    a_empty_length : assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && (m_status == olwd_pkg::ST_EMPTY)) |-> (m_length == '0))
        else $error("empty status with entries present");

endmodule

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
    import olwd_pkg::*;

    localparam int CAPACITY   = 64;
    localparam int STALL_LIMIT = 4000;
    localparam int HOLD_CYCLES = 300;

    typedef struct {
        logic signed [VALUE_W-1:0] item_value;
        logic                      last;
        logic [STATUS_W-1:0]       status;
        logic [LEN_W-1:0]          length;
    } list_result_t;

    class list_scoreboard;
        logic signed [VALUE_W-1:0] cells[$];
        list_result_t              expected_results[$];
        int                        errors;

        function new();
            errors = 0;
        endfunction

        function void push_result(logic signed [VALUE_W-1:0] item_value, logic last,
                                  logic [STATUS_W-1:0] status);
            list_result_t r;
            r.item_value = item_value;
            r.last       = last;
            r.status     = status;
            r.length     = LEN_W'(cells.size());
            expected_results.push_back(r);
        endfunction

        function void note_request(logic [ACTION_W-1:0] action,
                                   logic signed [VALUE_W-1:0] value);
            logic [STATUS_W-1:0] status;
            int                  n;
            bit                  found;
            status = ST_OK;
            n      = cells.size();
            case (action)
                ACT_APPEND: begin
                    if (n >= CAPACITY) status = ST_FULL;
                    else cells.push_back(value);
                end
                ACT_DEL_HEAD: begin
                    if (n == 0) status = ST_EMPTY;
                    else void'(cells.pop_front());
                end
                ACT_DEL_TAIL: begin
                    if (n == 0) status = ST_EMPTY;
                    else void'(cells.pop_back());
                end
                ACT_DEL_MATCH: begin
                    if (n == 0) begin
                        status = ST_EMPTY;
                    end else begin
                        found = 1'b0;
                        for (int i = 0; i < n && !found; i++) begin
                            if (cells[i] == value) begin
                                cells.delete(i);
                                found = 1'b1;
                            end
                        end
                        status = found ? ST_OK : ST_NOTFOUND;
                    end
                end
                ACT_DUMP: begin
                    if (n == 0) begin
                        push_result('0, 1'b1, ST_EMPTY);
                    end else begin
                        for (int i = 0; i < n; i++)
                            push_result(cells[i], i == n - 1, ST_OK);
                    end
                    return;
                end
                default: ;
            endcase
            push_result('0, 1'b1, status);
        endfunction

        function void check_result(logic signed [VALUE_W-1:0] item_value, logic last,
                                   logic [STATUS_W-1:0] status, logic [LEN_W-1:0] length);
            list_result_t e;
            if (expected_results.size() == 0) begin
                $error("unexpected result: item_value %0d last %0b status %0d length %0d",
                       item_value, last, status, length);
                errors++;
                return;
            end
            e = expected_results.pop_front();
            if (item_value !== e.item_value) begin
                $error("item_value mismatch: expected %0d, actual %0d", e.item_value,
                       item_value);
                errors++;
            end
            if (last !== e.last) begin
                $error("last mismatch: expected %0b, actual %0b", e.last, last);
                errors++;
            end
            if (status !== e.status) begin
                $error("status mismatch: expected %0d, actual %0d", e.status, status);
                errors++;
            end
            if (length !== e.length) begin
                $error("length mismatch: expected %0d, actual %0d", e.length, length);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic [ACTION_W-1:0]       s_action;
    logic signed [VALUE_W-1:0] s_value;
    logic                      m_valid;
    logic                      m_ready;
    logic signed [VALUE_W-1:0] m_item_value;
    logic                      m_last;
    logic [STATUS_W-1:0]       m_status;
    logic [LEN_W-1:0]          m_length;

    list_scoreboard sb;
    bit             no_idle;
    bit             rx_hold_req;
    int             quiet_cycles;

    ordered_list_with_deletions #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_item_value(m_item_value),
        .m_last      (m_last),
        .m_status    (m_status),
        .m_length    (m_length)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    task automatic send_request(input logic [ACTION_W-1:0] action,
                                input logic signed [VALUE_W-1:0] value);
        while (!no_idle && $urandom_range(0, 99) < 26) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid  = 1'b1;
        s_action = action;
        s_value  = value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(action, value);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid = 1'b0;
        while (sb.expected_results.size() != 0) @(negedge aclk);
    endtask

    function automatic logic [ACTION_W-1:0] ACT_ATTR_UNUSED();
        return ACTION_W'($urandom_range(ACT_DUMP + 1, 7));
    endfunction

    task automatic send_random_request(input int append_pct);
        int                        r;
        logic signed [VALUE_W-1:0] v;
        r = $urandom_range(0, 99);
        if ($urandom_range(0, 3) == 0) v = $signed($urandom_range(0, 7)) - 4;
        else v = $urandom;
        if (r < append_pct) begin
            send_request(ACT_APPEND, v);
        end else if (r < append_pct + 12) begin
            send_request(ACT_DEL_HEAD, v);
        end else if (r < append_pct + 24) begin
            send_request(ACT_DEL_TAIL, v);
        end else if (r < append_pct + 44) begin
            if (sb.cells.size() != 0 && $urandom_range(0, 9) < 7)
                v = sb.cells[$urandom_range(0, sb.cells.size() - 1)];
            send_request(ACT_DEL_MATCH, v);
        end else if (r < 96) begin
            send_request(ACT_DUMP, v);
        end else begin
            send_request(ACT_ATTR_UNUSED(), v);
        end
    endtask

    initial begin
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (rx_hold_req) begin
                m_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                rx_hold_req = 1'b0;
            end
            m_ready = no_idle || ($urandom_range(0, 99) >= 26);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_item_value, m_last, m_status, m_length);
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) quiet_cycles = 0;
        else quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("ordered_list_with_deletions regression: fail");
            $finish;
        end
    end

    initial begin
        sb           = new();
        no_idle      = 1'b0;
        rx_hold_req  = 1'b0;
        quiet_cycles = 0;
        aresetn      = 1'b0;
        s_valid      = 1'b0;
        s_action     = ACT_APPEND;
        s_value      = '0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        send_request(ACT_DUMP, 0);
        send_request(ACT_DEL_HEAD, 0);
        send_request(ACT_DEL_TAIL, 0);
        send_request(ACT_DEL_MATCH, 5);
        send_request(3'd5, 32'sh5555_5555);
        send_request(3'd6, 32'shAAAA_AAAA);
        send_request(3'd7, -1);
        send_request(ACT_APPEND, 32'sh8000_0000);
        send_request(ACT_APPEND, 32'sh7FFF_FFFF);
        send_request(ACT_APPEND, 0);
        send_request(ACT_APPEND, 7);
        send_request(ACT_APPEND, -1);
        send_request(ACT_APPEND, 7);
        send_request(ACT_DUMP, 0);
        send_request(ACT_DEL_MATCH, 7);
        send_request(ACT_DEL_MATCH, 99);
        send_request(ACT_DEL_MATCH, 32'sh8000_0000);
        send_request(ACT_DUMP, 0);
        send_request(ACT_DEL_HEAD, 0);
        send_request(ACT_DEL_TAIL, 0);
        send_request(3'd5, 0);
        send_request(ACT_DUMP, 0);
        wait_results_drained();

        for (int i = 0; i < 110; i++) begin
            no_idle = (i >= 40 && i < 90);
            send_random_request(45);
        end
        no_idle = 1'b0;

        rx_hold_req = 1'b1;
        while (sb.cells.size() < CAPACITY) send_request(ACT_APPEND, $urandom);
        repeat (3) send_request(ACT_APPEND, $urandom);
        send_request(ACT_DUMP, 0);
        send_request(ACT_DEL_MATCH, sb.cells[CAPACITY - 1]);
        send_request(ACT_DEL_MATCH, sb.cells[0]);
        send_request(ACT_APPEND, 32'sh7FFF_FFFF);
        send_request(ACT_APPEND, 32'sh8000_0000);
        send_request(ACT_DUMP, 0);

        for (int i = 0; i < 90; i++) send_random_request(20);
        while (sb.cells.size() != 0) send_request(ACT_DEL_TAIL, 0);
        send_request(ACT_DUMP, 0);

        wait_results_drained();
        repeat (CAPACITY + 16) @(posedge aclk);
        if (sb.expected_results.size() != 0) begin
            $error("%0d expected results never arrived", sb.expected_results.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("ordered_list_with_deletions regression: pass");
        end else begin
            $display("ordered_list_with_deletions regression: fail");
        end
        $finish;
    end
endmodule

/* files.f */
rtl/core/olwd_pkg.sv
rtl/core/olwd_front.sv
rtl/core/olwd_back.sv
rtl/core/ordered_list_with_deletions.sv
test/tb.sv
